// ----- hdl/bf3g_pkg.sv -----
// shared constants, types and helpers of the 3x3 box filter
package bf3g_pkg;

    localparam int PIX_W = 8;
    localparam int DIM_W = 13;
    localparam int DIMX_W = DIM_W + 1;
    localparam int POS_W = 12;
    localparam int SUM_W = 12;
    localparam int WIN_N = 9;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam logic [DIM_W-1:0] DEF_IMAGE_WIDTH = DIM_W'(1920);
    localparam logic [DIM_W-1:0] DEF_IMAGE_HEIGHT = DIM_W'(1080);
    localparam logic [DIMX_W-1:0] MIN_DIM = DIMX_W'(3);

    // floor(s / 9) = (s * 7282) >> 16 for every s up to 9 * 255
    localparam int DIV9_MULT_W = 13;
    localparam logic [DIV9_MULT_W-1:0] DIV9_MULT = DIV9_MULT_W'(7282);
    localparam int DIV9_SHIFT = 16;
    localparam int PROD_W = SUM_W + DIV9_MULT_W;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = REG_IDX_W'(1);

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             done;
    } meta_t;

    typedef struct packed {
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] pix;
    } column_t;

    function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(s) * PROD_W'(DIV9_MULT);
        return prod[DIV9_SHIFT +: PIX_W];
    endfunction

endpackage

// ----- hdl/bf3g_if.sv -----
// pixel request and filter result channels

interface bf3g_pix_if import bf3g_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;
    logic             start_of_frame;

    modport source (output valid, output pixel_in, output start_of_frame, input ready);
    modport sink (input valid, input pixel_in, input start_of_frame, output ready);
endinterface

interface bf3g_res_if import bf3g_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] mean_out;
    logic             out_valid;
    logic [POS_W-1:0] centre_row;
    logic [POS_W-1:0] centre_col;
    logic             frame_done;

    modport source (output valid, output mean_out, output out_valid, output centre_row,
                    output centre_col, output frame_done, input ready);
    modport sink (input valid, input mean_out, input out_valid, input centre_row,
                  input centre_col, input frame_done, output ready);
endinterface

// ----- hdl/bf3g_cfg.sv -----
// apb register file holding image width and height
module bf3g_cfg import bf3g_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic [DIM_W-1:0]      image_width,
    output logic [DIM_W-1:0]      image_height
);

    logic [DIM_W-1:0]     width_reg;
    logic [DIM_W-1:0]     height_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= DEF_IMAGE_WIDTH;
            height_reg <= DEF_IMAGE_HEIGHT;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_IMAGE_WIDTH:  width_reg <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    assign image_width = width_reg;
    assign image_height = height_reg;

endmodule

// ----- hdl/bf3g_scan.sv -----
// raster position counters and per-pixel window tags
module bf3g_scan import bf3g_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic             sof,
    input  logic [DIM_W-1:0] image_width,
    input  logic [DIM_W-1:0] image_height,
    output logic [CW-1:0]    idx,
    output meta_t            meta
);

    localparam logic [DIMX_W-1:0] MAX_W_X = DIMX_W'(MAX_WIDTH);
    localparam logic [DIMX_W-1:0] MAX_H_X = DIMX_W'(MAX_HEIGHT);

    logic [CW-1:0]     col_reg;
    logic [CW-1:0]     col_next;
    logic [RW-1:0]     row_reg;
    logic [RW-1:0]     row_next;
    logic [CW-1:0]     c_cur;
    logic [RW-1:0]     r_cur;
    logic [CW-1:0]     c_m1;
    logic [RW-1:0]     r_m1;
    logic [DIMX_W-1:0] w_x;
    logic [DIMX_W-1:0] h_x;
    logic [DIMX_W-1:0] w_eff;
    logic [DIMX_W-1:0] h_eff;
    logic              last_col;
    logic              last_row;
    logic              interior;

    assign w_x = DIMX_W'(image_width);
    assign h_x = DIMX_W'(image_height);

    // out-of-range sizes are clamped
    always_comb
    begin
        if (w_x < MIN_DIM)
            w_eff = MIN_DIM;
        else if (w_x > MAX_W_X)
            w_eff = MAX_W_X;
        else
            w_eff = w_x;
        if (h_x < MIN_DIM)
            h_eff = MIN_DIM;
        else if (h_x > MAX_H_X)
            h_eff = MAX_H_X;
        else
            h_eff = h_x;
    end

    assign c_cur = sof ? '0 : col_reg;
    assign r_cur = sof ? '0 : row_reg;
    assign last_col = (DIMX_W'(c_cur) + DIMX_W'(1)) >= w_eff;
    assign last_row = (DIMX_W'(r_cur) + DIMX_W'(1)) >= h_eff;
    assign interior = (DIMX_W'(c_cur) >= DIMX_W'(2)) && (DIMX_W'(r_cur) >= DIMX_W'(2));
    assign c_m1 = c_cur - CW'(1);
    assign r_m1 = r_cur - RW'(1);

    always_comb
    begin
        col_next = c_cur + CW'(1);
        row_next = r_cur;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : r_cur + RW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign idx = c_cur;
    assign meta.valid = interior;
    assign meta.row = interior ? POS_W'(r_m1) : '0;
    assign meta.col = interior ? POS_W'(c_m1) : '0;
    assign meta.done = last_col && last_row;

`ifndef SYNTHESIS
    localparam logic [DIMX_W-1:0] COL_LIM = DIMX_W'(MAX_WIDTH);
    localparam logic [DIMX_W-1:0] ROW_LIM = DIMX_W'(MAX_HEIGHT);

    a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (DIMX_W'(col_reg) < COL_LIM) && (DIMX_W'(row_reg) < ROW_LIM))
        else $error("position counter beyond maximum size");
`endif

endmodule

// ----- hdl/bf3g_line_mem.sv -----
// two line stores with read-modify-write and write forwarding
module bf3g_line_mem import bf3g_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int CW = $clog2(MAX_WIDTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [CW-1:0]    idx,
    input  logic [PIX_W-1:0] pix,
    input  meta_t            in_meta,
    output logic             col_valid,
    output column_t          col,
    output meta_t            col_meta
);

    logic [PIX_W-1:0] up_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] mid_mem [MAX_WIDTH];

    logic             accept;
    logic             wr_en;
    logic             s1_valid_reg;
    logic [CW-1:0]    s1_idx_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    meta_t            s1_meta_reg;
    logic [PIX_W-1:0] rd_up_reg;
    logic [PIX_W-1:0] rd_mid_reg;
    logic             fwd_hit_reg;
    logic [PIX_W-1:0] fwd_up_reg;
    logic [PIX_W-1:0] fwd_mid_reg;
    logic [PIX_W-1:0] up_eff;
    logic [PIX_W-1:0] mid_eff;

    assign accept = en && in_valid;
    assign wr_en = en && s1_valid_reg;

    // the write of the leaving request is not seen by a read in the same cycle
    assign up_eff = fwd_hit_reg ? fwd_up_reg : rd_up_reg;
    assign mid_eff = fwd_hit_reg ? fwd_mid_reg : rd_mid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            up_mem[s1_idx_reg] <= mid_eff;
            mid_mem[s1_idx_reg] <= s1_pix_reg;
        end
        if (accept)
        begin
            rd_up_reg <= up_mem[idx];
            rd_mid_reg <= mid_mem[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            if (in_valid)
                fwd_hit_reg <= s1_valid_reg && (s1_idx_reg == idx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg <= idx;
            s1_pix_reg <= pix;
            s1_meta_reg <= in_meta;
            fwd_up_reg <= mid_eff;
            fwd_mid_reg <= s1_pix_reg;
        end
    end

    assign col_valid = s1_valid_reg;
    assign col.up = up_eff;
    assign col.mid = mid_eff;
    assign col.pix = s1_pix_reg;
    assign col_meta = s1_meta_reg;

`ifndef SYNTHESIS
    a_fwd_on_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_valid_reg && (s1_idx_reg == idx)) |=> fwd_hit_reg)
        else $error("back-to-back access to one entry not forwarded");
`endif

endmodule

// ----- hdl/bf3g_mean.sv -----
// 3x3 window, window sum and division by nine
module bf3g_mean import bf3g_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             col_valid,
    input  column_t          col,
    input  meta_t            col_meta,
    output logic             out_valid,
    output logic [PIX_W-1:0] out_mean,
    output meta_t            out_meta
);

    logic [PIX_W-1:0] win_reg [WIN_N];
    logic             v2_reg;
    meta_t            meta2_reg;
    logic             v3_reg;
    meta_t            meta3_reg;
    logic [SUM_W-1:0] sum3_reg;
    logic             vo_reg;
    meta_t            meta_o_reg;
    logic [PIX_W-1:0] mean_o_reg;
    logic [SUM_W-1:0] win_sum;

    always_comb
    begin
        win_sum = '0;
        for (int k = 0; k < WIN_N; k++)
            win_sum = win_sum + SUM_W'(win_reg[k]);
    end

    // rows top to bottom, newest column on the right
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WIN_N; k++)
                win_reg[k] <= '0;
        end
        else if (en && col_valid)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k*3]     <= win_reg[k*3 + 1];
                win_reg[k*3 + 1] <= win_reg[k*3 + 2];
            end
            win_reg[2] <= col.up;
            win_reg[5] <= col.mid;
            win_reg[8] <= col.pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= col_valid;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta2_reg <= col_meta;
            meta3_reg <= meta2_reg;
            sum3_reg <= win_sum;
            meta_o_reg <= meta3_reg;
            mean_o_reg <= meta3_reg.valid ? div9(sum3_reg) : '0;
        end
    end

    assign out_valid = vo_reg;
    assign out_mean = mean_o_reg;
    assign out_meta = meta_o_reg;

`ifndef SYNTHESIS
    a_centre_interior: assert property (@(posedge clk) disable iff (!rst_n)
        (vo_reg && meta_o_reg.valid) |-> (meta_o_reg.row != '0) && (meta_o_reg.col != '0))
        else $error("valid mean at a border position");
`endif

endmodule

// ----- hdl/box_filter_3x3_gray_core.sv -----
// top level of the streaming 3x3 box filter
//
//  channel   dir  fields                                              handshake
//  pix       in   pixel_in, start_of_frame                            valid/ready
//  res       out  mean_out, out_valid, centre_row, centre_col,        valid/ready
//                 frame_done
//  apb       in   image_width (0x0), image_height (0x4)               psel/penable
//
//  one request per clock while no result is held, one result per request, via the line
//  store, window, sum and mean registers; the line stores take one read and one write per cycle
//  reset clears counters, window and pipeline valids; line stores are not cleared
//  a stalled result freezes the whole pipeline, ready drops only while it is held
module box_filter_3x3_gray_core import bf3g_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    bf3g_pix_if.sink              pix,
    bf3g_res_if.source            res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic             en;
    logic             accept;
    logic [CW-1:0]    idx;
    meta_t            in_meta;
    logic             col_valid;
    column_t          col;
    meta_t            col_meta;
    logic             out_valid;
    logic [PIX_W-1:0] out_mean;
    meta_t            out_meta;

    assign en = !out_valid || res.ready;
    assign accept = pix.valid && en;
    assign pix.ready = en;
    assign pready = 1'b1;

    bf3g_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .image_width  (image_width),
        .image_height (image_height)
    );

    bf3g_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .sof          (pix.start_of_frame),
        .image_width  (image_width),
        .image_height (image_height),
        .idx          (idx),
        .meta         (in_meta)
    );

    bf3g_line_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pix.valid),
        .idx       (idx),
        .pix       (pix.pixel_in),
        .in_meta   (in_meta),
        .col_valid (col_valid),
        .col       (col),
        .col_meta  (col_meta)
    );

    bf3g_mean u_mean (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .col_valid (col_valid),
        .col       (col),
        .col_meta  (col_meta),
        .out_valid (out_valid),
        .out_mean  (out_mean),
        .out_meta  (out_meta)
    );

    assign res.valid = out_valid;
    assign res.mean_out = out_mean;
    assign res.out_valid = out_meta.valid;
    assign res.centre_row = out_meta.row;
    assign res.centre_col = out_meta.col;
    assign res.frame_done = out_meta.done;

endmodule
